FILE: src/sms_pkg.sv
// Shared types and constants for the sorted multiset table.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none

package sms_pkg;

    // Default sizing of the table
    localparam int CAPACITY_DEF   = 16;
    localparam int VALUE_BITS_DEF = 32;

    // Fixed payload widths of the request and response channels
    localparam int CMD_W   = 2;
    localparam int KEY_W   = 32;
    localparam int COUNT_W = 5;

    // Request opcodes
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 2'd0,
        CMD_REMOVE  = 2'd1,
        CMD_REPLACE = 2'd2,
        CMD_SEARCH  = 2'd3
    } t_cmd;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_TEST,
        S_SCAN_EV,
        S_POST,
        S_INS_TEST,
        S_INS_EV,
        S_FIN
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture a new request
        logic reject;     // insert refused, table full
        logic scan_init;  // start a forward pass
        logic scan_rd;    // read the entry under the scan pointer
        logic scan_ev;    // evaluate the entry just read
        logic scan_done;  // commit the compacted count
        logic ins_init;   // start a backward insert pass
        logic ins_rd;     // read the entry below the read pointer
        logic ins_ev;     // evaluate the entry just read
        logic ins_put;    // drop one copy of the new value
        logic finish;     // load the response register
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        t_cmd op;
        logic full;
        logic scan_end;
        logic ins_done;
        logic ins_have;
        logic match_nz;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: src/sms_if.sv
// Request and response channel interfaces of the sorted multiset table.
// Depends on sms_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface sms_req_if;
    logic                                valid;
    logic                                ready;
    logic        [sms_pkg::CMD_W-1:0]    cmd;
    logic signed [sms_pkg::KEY_W-1:0]    key;
    logic signed [sms_pkg::KEY_W-1:0]    new_value;

    modport source (output valid, cmd, key, new_value, input ready);
    modport sink   (input valid, cmd, key, new_value, output ready);
endinterface

interface sms_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                status;
    logic        [sms_pkg::COUNT_W-1:0]  match_count;
    logic                                found;
    logic        [sms_pkg::COUNT_W-1:0]  occupancy;

    modport source (output valid, status, match_count, found, occupancy, input ready);
    modport sink   (input valid, status, match_count, found, occupancy, output ready);
endinterface

`default_nettype wire

FILE: src/sms_datapath.sv
// Datapath of the sorted multiset table: entry memory, pointers, counters
// and the response register. Depends on sms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sms_datapath #(
    parameter int CAPACITY   = sms_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = sms_pkg::VALUE_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire sms_pkg::t_dp_cmd                    i_cmd,
    output      sms_pkg::t_dp_sts                    o_sts,
    input  wire logic        [sms_pkg::CMD_W-1:0]    i_op,
    input  wire logic signed [sms_pkg::KEY_W-1:0]    i_key,
    input  wire logic signed [sms_pkg::KEY_W-1:0]    i_new_value,
    output      logic                                o_status,
    output      logic        [sms_pkg::COUNT_W-1:0]  o_match_count,
    output      logic                                o_found,
    output      logic        [sms_pkg::COUNT_W-1:0]  o_occupancy
);
    import sms_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // Entry memory, only positions below the count are ever read
    logic signed [VALUE_BITS-1:0] r_mem [CAPACITY];
    logic signed [VALUE_BITS-1:0] r_rdata;

    t_cmd                         r_op;
    logic signed [VALUE_BITS-1:0] r_key;
    logic signed [VALUE_BITS-1:0] r_nv;
    logic signed [VALUE_BITS-1:0] r_val;
    logic [CW-1:0]                r_count;
    logic [CW-1:0]                r_rd;
    logic [CW-1:0]                r_wp;
    logic [CW-1:0]                r_copies;
    logic [CW-1:0]                r_matches;
    logic                         r_reject;

    logic [CW-1:0]                n_copies;
    logic [CW-1:0]                w_rd_m1;
    logic [CW-1:0]                w_wp_m1;
    logic                         w_eq;
    logic                         w_gt;
    logic                         w_we;
    logic [AW-1:0]                w_waddr;
    logic signed [VALUE_BITS-1:0] w_wdata;
    logic                         w_re;
    logic [AW-1:0]                w_raddr;

    assign w_rd_m1 = r_rd - CW'(1);
    assign w_wp_m1 = r_wp - CW'(1);
    assign w_eq    = (r_rdata == r_key);
    assign w_gt    = (r_rdata > r_val);
    assign n_copies = (r_op == CMD_INSERT) ? CW'(1) : r_matches;

    // Status toward the controller
    always_comb begin
        o_sts.op       = r_op;
        o_sts.full     = (r_count == CW'(CAPACITY));
        o_sts.scan_end = (r_rd == r_count);
        o_sts.ins_done = (r_copies == '0);
        o_sts.ins_have = (r_rd != '0);
        o_sts.match_nz = (r_matches != '0);
    end

    // Memory port control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_wp[AW-1:0];
        w_wdata = r_rdata;
        if (i_cmd.scan_ev && !w_eq && r_op != CMD_SEARCH) begin
            w_we = 1'b1;
        end else if (i_cmd.ins_ev) begin
            w_we    = 1'b1;
            w_waddr = w_wp_m1[AW-1:0];
            w_wdata = w_gt ? r_rdata : r_val;
        end else if (i_cmd.ins_put) begin
            w_we    = 1'b1;
            w_waddr = w_wp_m1[AW-1:0];
            w_wdata = r_val;
        end
        w_re    = i_cmd.scan_rd || i_cmd.ins_rd;
        w_raddr = i_cmd.ins_rd ? w_rd_m1[AW-1:0] : r_rd[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.scan_done && r_op != CMD_SEARCH) begin
            r_count <= r_wp;
        end else if (i_cmd.ins_init) begin
            r_count <= r_count + n_copies;
        end
    end

    // Request capture, pointers and counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= t_cmd'(i_op);
            r_key    <= VALUE_BITS'(i_key);
            r_nv     <= VALUE_BITS'(i_new_value);
            r_reject <= 1'b0;
            r_matches <= '0;
        end
        if (i_cmd.reject) begin
            r_reject <= 1'b1;
        end
        if (i_cmd.scan_init) begin
            r_rd      <= '0;
            r_wp      <= '0;
            r_matches <= '0;
        end
        if (i_cmd.scan_ev) begin
            r_rd <= r_rd + CW'(1);
            if (w_eq) begin
                r_matches <= r_matches + CW'(1);
            end else if (r_op != CMD_SEARCH) begin
                r_wp <= r_wp + CW'(1);
            end
        end
        if (i_cmd.ins_init) begin
            r_rd     <= r_count;
            r_wp     <= r_count + n_copies;
            r_copies <= n_copies;
            r_val    <= (r_op == CMD_INSERT) ? r_key : r_nv;
        end
        if (i_cmd.ins_ev) begin
            r_wp <= w_wp_m1;
            if (w_gt) begin
                r_rd <= w_rd_m1;
            end else begin
                r_copies <= r_copies - CW'(1);
            end
        end
        if (i_cmd.ins_put) begin
            r_wp     <= w_wp_m1;
            r_copies <= r_copies - CW'(1);
        end
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_status    <= r_reject;
            o_found     <= (r_op == CMD_SEARCH) && (r_matches != '0);
            o_occupancy <= COUNT_W'(r_count);
            case (r_op)
                CMD_INSERT: o_match_count <= r_reject ? '0 : COUNT_W'(1);
                CMD_SEARCH: o_match_count <= '0;
                default:    o_match_count <= COUNT_W'(r_matches);
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: src/sms_ctrl.sv
// Controller of the sorted multiset table: sequences scan and insert passes
// and owns the channel handshakes. Depends on sms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sms_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    output      logic              o_req_ready,
    output      logic              o_rsp_valid,
    input  wire logic              i_rsp_ready,
    input  wire sms_pkg::t_dp_sts  i_sts,
    output      sms_pkg::t_dp_cmd  o_cmd
);
    import sms_pkg::*;

    t_state r_state, n_state;
    logic   r_rsp_valid;
    logic   w_rsp_free;

    assign w_rsp_free  = !r_rsp_valid || i_rsp_ready;
    assign o_rsp_valid = r_rsp_valid;
    assign o_req_ready = (r_state == S_IDLE);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Response valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (o_cmd.finish) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.op == CMD_INSERT) begin
                    if (i_sts.full) begin
                        o_cmd.reject = 1'b1;
                        n_state      = S_FIN;
                    end else begin
                        o_cmd.ins_init = 1'b1;
                        n_state        = S_INS_TEST;
                    end
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN_TEST;
                end
            end
            S_SCAN_TEST: begin
                if (i_sts.scan_end) begin
                    o_cmd.scan_done = 1'b1;
                    n_state         = S_POST;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    n_state       = S_SCAN_EV;
                end
            end
            S_SCAN_EV: begin
                o_cmd.scan_ev = 1'b1;
                n_state       = S_SCAN_TEST;
            end
            S_POST: begin
                // replace inserts one copy of the new value per removed match, in sorted place
                if (i_sts.op == CMD_REPLACE && i_sts.match_nz) begin
                    o_cmd.ins_init = 1'b1;
                    n_state        = S_INS_TEST;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_INS_TEST: begin
                if (i_sts.ins_done) begin
                    n_state = S_FIN;
                end else if (i_sts.ins_have) begin
                    o_cmd.ins_rd = 1'b1;
                    n_state      = S_INS_EV;
                end else begin
                    o_cmd.ins_put = 1'b1;
                end
            end
            S_INS_EV: begin
                o_cmd.ins_ev = 1'b1;
                n_state      = S_INS_TEST;
            end
            S_FIN: begin
                if (w_rsp_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/sorted_multiset_table.sv
// Sorted multiset table: keeps signed values in ascending order, duplicates allowed.
//
// Channels: i_req carries cmd (insert, remove all, replace all, search), key and
// new_value; o_rsp returns status, match_count, found and occupancy, one response
// per request, in order. Both use valid/ready; a request moves when both are high.
//
// Work per request is set by the entry memory: each entry is read in one state
// and evaluated in the next. Search and remove scan every entry; insert moves
// up only the entries greater than the key, and is refused with no pass when
// full; replace scans first, then inserts one copy of new_value per match.
// One request is in work at a time; i_req.ready is high only while idle.
//
// Reset (synchronous, active low) empties the table at once; stale entries are
// never read. A response waits in its output register while o_rsp.ready is low;
// the next request is still accepted, and its result waits until the register
// frees.
// Depends on sms_pkg, sms_if, sms_ctrl and sms_datapath.
`timescale 1ns / 1ps
`default_nettype none

module sorted_multiset_table #(
    parameter int CAPACITY   = sms_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = sms_pkg::VALUE_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sms_req_if.sink    i_req,
    sms_rsp_if.source  o_rsp
);
    import sms_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    sms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    sms_datapath #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_op          (i_req.cmd),
        .i_key         (i_req.key),
        .i_new_value   (i_req.new_value),
        .o_status      (o_rsp.status),
        .o_match_count (o_rsp.match_count),
        .o_found       (o_rsp.found),
        .o_occupancy   (o_rsp.occupancy)
    );

endmodule

`default_nettype wire

FILE: src/sms_checker.sv
// Port-level checks for the sorted multiset table, bound to the top level.
// Depends on sms_pkg and sorted_multiset_table.
`timescale 1ns / 1ps
`default_nettype none

module sms_checker #(
    parameter int CAPACITY = sms_pkg::CAPACITY_DEF
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_rsp_valid,
    input wire logic                          i_rsp_ready,
    input wire logic                          i_rsp_status,
    input wire logic [sms_pkg::COUNT_W-1:0]   i_rsp_match_count,
    input wire logic                          i_rsp_found,
    input wire logic [sms_pkg::COUNT_W-1:0]   i_rsp_occupancy
);
    import sms_pkg::*;

    localparam logic [COUNT_W-1:0] CAP_MASKED = COUNT_W'(CAPACITY);

    // no response comes out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid right after reset");

    // a rejected insert means the table is full and nothing matched
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status |->
            i_rsp_match_count == '0 && !i_rsp_found && i_rsp_occupancy == CAP_MASKED)
        else $error("rejected insert with inconsistent fields");

    // a search that finds the key reports no match count and no rejection
    a_found_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_found |-> i_rsp_match_count == '0 && !i_rsp_status)
        else $error("found set together with a match count");

    // a stalled response stays valid and keeps its occupancy
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_occupancy))
        else $error("response dropped or changed while stalled");

endmodule

bind sorted_multiset_table sms_checker #(.CAPACITY(CAPACITY)) u_sms_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_status      (o_rsp.status),
    .i_rsp_match_count (o_rsp.match_count),
    .i_rsp_found       (o_rsp.found),
    .i_rsp_occupancy   (o_rsp.occupancy)
);

`default_nettype wire
